FILE: rtl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared constants for the decimal coefficient parser: character codes,
// digit limits and the field widths of the input and result requests.
// ----------------------------------------------------------------------------
package dcp_pkg;

    // Limits on the digits that a number may carry.
    localparam int MAX_INT_DIGITS  = 2;
    localparam int MAX_FRAC_DIGITS = 8;

    // Counter widths that follow from the limits.
    localparam int INT_CNT_W  = $clog2(MAX_INT_DIGITS + 1);
    localparam int FRAC_CNT_W = 4;

    // Field widths of the requests.
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 30;
    localparam int RESULT_W    = 1 + VALUE_W + FRAC_CNT_W;
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;
    localparam int PRODUCT_W   = VALUE_W + 4;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    // The value keeps only its low nine decimal digits.
    localparam logic [VALUE_W-1:0] VALUE_MOD = 30'd1000000000;

endpackage

FILE: rtl/decimal_coefficient_parser_core.sv
// ----------------------------------------------------------------------------
// decimal_coefficient_parser_core
// Turns the ASCII characters of one decimal number into a scaled integer and
// a count of fraction digits, one character per cycle save a stalled last one.
// ----------------------------------------------------------------------------
// Usage
// The slave channel carries one character per request in s_tdata; s_tlast
// marks the final character of a number. No result is produced for the
// other characters. After the request marked last, one result request
// leaves on the master channel: bit 0 says whether the string was accepted,
// then the value (30 bits, the kept digits as one integer modulo 10^9, or 1
// when rejected) and the number of fraction digits (4 bits, 0 if rejected).
//
// A character is registered on acceptance and its effect on the parse state
// is worked out from that register. The result request is then registered
// in the result register once the last character can leave the input
// register. One character is taken in every cycle while no last character
// waits; the rate is set by the combinational multiply-by-ten and modulo step.
//
// A synchronous active-low reset clears the parse state and the valid flags
// of both request registers. When the receiver stalls, ordinary characters
// still flow into the parse state; only a last character waits in the input
// register until the result register is free, and then s_tready falls.
// ----------------------------------------------------------------------------
module decimal_coefficient_parser_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Character input.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcp_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] char_code
    input  logic                           s_tlast,
    // Result output.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dcp_pkg::M_TDATA_W-1:0]  m_tdata    // [0] accepted,
                                                      // [30:1] value,
                                                      // [34:31] frac_digits,
                                                      // [39:35] zero
);
    import dcp_pkg::*;

    // Input register.
    logic                    in_valid_reg;
    logic [CHAR_W-1:0]       in_char_reg;
    logic                    in_last_reg;

    // Parse state.
    logic [INT_CNT_W-1:0]    int_count_reg,     int_count_next;
    logic [FRAC_CNT_W-1:0]   frac_count_reg,    frac_count_next;
    logic                    dot_seen_reg,      dot_seen_next;
    logic                    stopped_reg,       stopped_next;
    logic                    rejected_reg,      rejected_next;
    logic [VALUE_W-1:0]      running_value_reg, running_value_next;
    logic [VALUE_W-1:0]      kept_value_reg,    kept_value_next;
    logic [FRAC_CNT_W-1:0]   kept_frac_reg,     kept_frac_next;

    // Result register.
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    out_free;
    logic                    advance;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [PRODUCT_W-1:0]    product;
    logic [PRODUCT_W-1:0]    wrap_sub;
    logic [VALUE_W-1:0]      pushed_value;
    logic                    result_reject;
    logic [RESULT_W-1:0]     result;

    // A character in the input register moves on unless it is a last
    // character and the previous result has not yet been taken.
    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign is_digit = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign digit    = 4'(in_char_reg - CH_ZERO);

    // Multiply by ten and add the digit, then bring the sum back below 10^9.
    // The sum stays below ten times the modulus, so nine parallel compares
    // pick the multiple to take off.
    always_comb begin
        product  = {running_value_reg, 3'b000} + {3'b000, running_value_reg, 1'b0}
                 + PRODUCT_W'(digit);
        wrap_sub = '0;
        for (int m = 1; m <= 9; m++) begin
            if (product >= PRODUCT_W'(m) * PRODUCT_W'(VALUE_MOD)) begin
                wrap_sub = PRODUCT_W'(m) * PRODUCT_W'(VALUE_MOD);
            end
        end
        pushed_value = VALUE_W'(product - wrap_sub);
    end

    // Effect of one character on the parse state.
    always_comb begin
        int_count_next     = int_count_reg;
        frac_count_next    = frac_count_reg;
        dot_seen_next      = dot_seen_reg;
        stopped_next       = stopped_reg;
        rejected_next      = rejected_reg;
        running_value_next = running_value_reg;
        kept_value_next    = kept_value_reg;
        kept_frac_next     = kept_frac_reg;

        if (!stopped_reg && !rejected_reg) begin
            if (in_char_reg == CH_NUL) begin
                stopped_next = 1'b1;
            end else if (in_char_reg == CH_DOT) begin
                if (dot_seen_reg) begin
                    rejected_next = 1'b1;
                end else begin
                    dot_seen_next = 1'b1;
                end
            end else if (!is_digit) begin
                rejected_next = 1'b1;
            end else if (!dot_seen_reg) begin
                // Leading zeros of the integer part are skipped.
                if (int_count_reg == '0 && digit == 4'd0) begin
                    int_count_next = int_count_reg;
                end else if (int_count_reg >= INT_CNT_W'(MAX_INT_DIGITS)) begin
                    rejected_next = 1'b1;
                end else begin
                    int_count_next     = int_count_reg + 1'b1;
                    running_value_next = pushed_value;
                    kept_value_next    = pushed_value;
                    kept_frac_next     = '0;
                end
            end else if (frac_count_reg >= FRAC_CNT_W'(MAX_FRAC_DIGITS)) begin
                // A surplus fraction digit ends parsing silently.
                stopped_next = 1'b1;
            end else begin
                frac_count_next    = frac_count_reg + 1'b1;
                running_value_next = pushed_value;
                // Only a nonzero digit moves the kept point, which strips
                // trailing zeros.
                if (digit != 4'd0) begin
                    kept_value_next = pushed_value;
                    kept_frac_next  = frac_count_reg + 1'b1;
                end
            end
        end
    end

    // A zero or empty number is rejected along with the malformed ones.
    assign result_reject = rejected_next || (int_count_next == '0 && kept_frac_next == '0);

    always_comb begin
        if (result_reject) begin
            result = {{FRAC_CNT_W{1'b0}}, VALUE_W'(1), 1'b0};
        end else begin
            result = {kept_frac_next, kept_value_next, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // The parse state starts afresh after every result.
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            int_count_reg     <= '0;
            frac_count_reg    <= '0;
            dot_seen_reg      <= 1'b0;
            stopped_reg       <= 1'b0;
            rejected_reg      <= 1'b0;
            running_value_reg <= '0;
            kept_value_reg    <= '0;
            kept_frac_reg     <= '0;
        end else if (advance) begin
            int_count_reg     <= int_count_next;
            frac_count_reg    <= frac_count_next;
            dot_seen_reg      <= dot_seen_next;
            stopped_reg       <= stopped_next;
            rejected_reg      <= rejected_next;
            running_value_reg <= running_value_next;
            kept_value_reg    <= kept_value_next;
            kept_frac_reg     <= kept_frac_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_tdata_reg <= M_TDATA_W'(result);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/dcp_checker.sv
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level checks on the decimal coefficient parser, bound to its top level.
// ----------------------------------------------------------------------------
module dcp_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dcp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dcp_pkg::*;

    logic                  res_accepted;
    logic [VALUE_W-1:0]    res_value;
    logic [FRAC_CNT_W-1:0] res_frac;

    assign res_accepted = m_tdata[0];
    assign res_value    = m_tdata[VALUE_W:1];
    assign res_frac     = m_tdata[RESULT_W-1:VALUE_W+1];

    // Reset leaves no result request pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request valid after reset");

    // A stalled result request holds its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result request changed");

    // A rejected string always reports value 1 and no fraction digits.
    a_reject_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res_accepted |-> res_value == VALUE_W'(1) && res_frac == '0)
        else $error("rejected result malformed");

    // An accepted number is nonzero, below 10^9, within the fraction limit.
    a_accept_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_accepted |-> res_value != '0 && res_value < VALUE_MOD
            && res_frac <= FRAC_CNT_W'(MAX_FRAC_DIGITS))
        else $error("accepted result out of range");

endmodule

bind decimal_coefficient_parser_core dcp_checker u_dcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
